>>> design/kct_pkg.sv
package kct_pkg;

  localparam int TpsW = 10;
  localparam int SecW = 12;
  localparam int DigW = 6;

  localparam logic [7:0] KEY_SET  = 8'h2A;
  localparam logic [7:0] KEY_GO   = 8'h23;
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;

  localparam logic [3:0]      TENS_MAX  = 4'd5;
  localparam logic [1:0]      LEDS_ON   = 2'b11;
  localparam logic [TpsW-1:0] TPS_RESET = 10'd20;
  localparam logic [2:0]      POS_COLON = 3'd2;
  localparam logic [2:0]      POS_FULL  = 3'd4;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ENTRY = 2'd1;
  localparam logic [1:0] MODE_ARMED = 2'd2;
  localparam logic [1:0] MODE_COUNT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ENTRY = 4'b0010,
    ST_ARMED = 4'b0100,
    ST_COUNT = 4'b1000
  } state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] key_code;
  } evt_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [1:0]      leds;
    logic            echo_valid;
    logic [3:0]      echo_digit;
    logic            colon_mark;
    logic            time_valid;
    logic [SecW-1:0] seconds_left;
    logic            prompt_reset;
  } res_t;

  function automatic logic [1:0] mode_code(input state_t st);
    logic [1:0] m;
    unique case (st)
      ST_IDLE:  m = MODE_IDLE;
      ST_ENTRY: m = MODE_ENTRY;
      ST_ARMED: m = MODE_ARMED;
      ST_COUNT: m = MODE_COUNT;
      default:  m = MODE_IDLE;
    endcase
    return m;
  endfunction

  // shift-and-add / shift-and-subtract products, no multiplier
  function automatic logic [DigW-1:0] times_ten(input logic [DigW-1:0] v);
    logic [DigW-1:0] p;
    p = (v << 3) + (v << 1);
    return p;
  endfunction

  function automatic logic [SecW-1:0] times_sixty(input logic [DigW-1:0] v);
    logic [SecW-1:0] w;
    logic [SecW-1:0] p;
    w = {{(SecW-DigW){1'b0}}, v};
    p = (w << 6) - (w << 2);
    return p;
  endfunction

endpackage

>>> design/kct_if.sv
interface kct_evt_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key_code;

  modport source (output valid, output op, output key_code, input ready);
  modport sink   (input valid, input op, input key_code, output ready);
endinterface

interface kct_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  leds;
  logic        echo_valid;
  logic [3:0]  echo_digit;
  logic        colon_mark;
  logic        time_valid;
  logic [11:0] seconds_left;
  logic        prompt_reset;

  modport source (
    output valid, output mode, output leds, output echo_valid, output echo_digit,
    output colon_mark, output time_valid, output seconds_left, output prompt_reset,
    input ready
  );
  modport sink (
    input valid, input mode, input leds, input echo_valid, input echo_digit,
    input colon_mark, input time_valid, input seconds_left, input prompt_reset,
    output ready
  );
endinterface

>>> design/kct_in_stage.sv
module kct_in_stage (
  input  logic            clk,
  input  logic            rst,
  kct_evt_if.sink         evt,
  input  logic            advance,
  output logic            hold_valid,
  output kct_pkg::evt_t   hold
);
  import kct_pkg::*;

  logic accept;

  assign evt.ready = !hold_valid || advance;
  assign accept    = evt.valid && evt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= '{op: evt.op, key_code: evt.key_code};
    end
  end

endmodule

>>> design/kct_step.sv
module kct_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [kct_pkg::TpsW-1:0]   cfg_wdata,
  input  logic                       fire,
  input  kct_pkg::evt_t              item,
  output kct_pkg::res_t              result
);
  import kct_pkg::*;

  logic [TpsW-1:0] ticks_per_second;
  state_t          st, st_next;
  logic [2:0]      pos, pos_next;
  logic [DigW-1:0] mins, mins_next;
  logic [DigW-1:0] secs, secs_next;
  logic [SecW-1:0] rem, rem_next;
  logic [TpsW-1:0] sub, sub_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (cfg_we) begin
      ticks_per_second <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_IDLE;
      pos  <= '0;
      mins <= '0;
      secs <= '0;
      rem  <= '0;
      sub  <= '0;
    end else if (fire) begin
      st   <= st_next;
      pos  <= pos_next;
      mins <= mins_next;
      secs <= secs_next;
      rem  <= rem_next;
      sub  <= sub_next;
    end
  end

  always_comb begin
    logic [TpsW-1:0] tps;
    logic [3:0]      d;
    logic            is_digit;
    logic [2:0]      pos_inc;
    logic [DigW-1:0] mins_acc;
    logic [DigW-1:0] secs_acc;
    logic [TpsW-1:0] sub_dec;
    logic [SecW-1:0] rem_dec;

    tps      = (ticks_per_second == '0) ? TpsW'(1) : ticks_per_second;
    is_digit = (item.key_code >= KEY_ZERO) && (item.key_code <= KEY_NINE);
    d        = item.key_code[3:0];
    // tens digits clamp at five
    if (!pos[0] && (d > TENS_MAX)) begin
      d = TENS_MAX;
    end
    pos_inc  = pos + 3'd1;
    mins_acc = times_ten(mins) + {2'b00, d};
    secs_acc = times_ten(secs) + {2'b00, d};
    sub_dec  = (sub == '0) ? (tps - TpsW'(1)) : (sub - TpsW'(1));
    rem_dec  = (sub == '0) ? (rem - SecW'(1)) : rem;

    st_next   = st;
    pos_next  = pos;
    mins_next = mins;
    secs_next = secs;
    rem_next  = rem;
    sub_next  = sub;
    result    = '0;

    if (!item.op) begin
      if (item.key_code == KEY_SET) begin
        // starts entry from idle, aborts from any other mode
        pos_next  = '0;
        mins_next = '0;
        secs_next = '0;
        rem_next  = '0;
        sub_next  = '0;
        st_next   = (st == ST_IDLE) ? ST_ENTRY : ST_IDLE;
        result.prompt_reset = (st != ST_IDLE);
      end else begin
        unique case (st)
          ST_ENTRY: begin
            if (is_digit) begin
              if (pos < POS_COLON) begin
                mins_next = mins_acc;
              end else begin
                secs_next = secs_acc;
              end
              pos_next          = pos_inc;
              result.echo_valid = 1'b1;
              result.echo_digit = d;
              result.colon_mark = (pos_inc == POS_COLON);
              if (pos_inc >= POS_FULL) begin
                st_next  = ST_ARMED;
                rem_next = times_sixty(mins) + {{(SecW-DigW){1'b0}}, secs_acc};
                sub_next = '0;
              end
            end
          end
          ST_ARMED: begin
            if (item.key_code == KEY_GO) begin
              if (rem == '0) begin
                st_next   = ST_IDLE;
                pos_next  = '0;
                mins_next = '0;
                secs_next = '0;
                sub_next  = '0;
                result.prompt_reset = 1'b1;
              end else begin
                st_next  = ST_COUNT;
                sub_next = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else if (st == ST_COUNT) begin
      rem_next = rem_dec;
      sub_next = sub_dec;
      if (sub_dec == '0) begin
        result.time_valid   = 1'b1;
        result.seconds_left = rem_dec;
        if (rem_dec == '0) begin
          st_next   = ST_IDLE;
          pos_next  = '0;
          mins_next = '0;
          secs_next = '0;
          result.prompt_reset = 1'b1;
        end
      end
    end

    result.mode = mode_code(st_next);
    result.leds = ((st_next == ST_ARMED) || (st_next == ST_COUNT)) ? LEDS_ON : 2'b00;
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> (pos == '0 && mins == '0 && secs == '0 && rem == '0 && sub == '0))
    else $error("idle with leftover timer state");

  a_entry_pos: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ENTRY) |-> (pos < POS_FULL))
    else $error("entry with full digit count");

  a_armed_pos: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ARMED) |-> (pos == POS_FULL))
    else $error("armed without four digits");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (st == ST_COUNT) |-> (rem != '0 || sub != '0))
    else $error("counting with nothing left");

  a_prompt_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && result.prompt_reset) |=> (st == ST_IDLE))
    else $error("prompt without return to idle");

endmodule

>>> design/kct_out_stage.sv
module kct_out_stage (
  input  logic            clk,
  input  logic            rst,
  kct_res_if.source       res,
  input  logic            load,
  input  kct_pkg::res_t   data,
  output logic            space
);
  import kct_pkg::*;

  res_t held;

  assign space = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign res.mode         = held.mode;
  assign res.leds         = held.leds;
  assign res.echo_valid   = held.echo_valid;
  assign res.echo_digit   = held.echo_digit;
  assign res.colon_mark   = held.colon_mark;
  assign res.time_valid   = held.time_valid;
  assign res.seconds_left = held.seconds_left;
  assign res.prompt_reset = held.prompt_reset;

endmodule

>>> design/keypad_countdown_timer.sv
// keypad countdown timer, mm:ss
// evt channel: one beat per key event (op 0, ascii key_code) or tick (op 1)
// res channel: exactly one result beat per event beat, in order
// cfg_we / cfg_wdata write ticks_per_second; write it only with no beat in flight
// throughput: one event per cycle while res takes each beat; the timer
//   state loop is a single registered update, so only res back-pressure
//   holds the rate below one per cycle
// a two-register path (input register, result register) separates the
//   channels, so a new event is taken while a result still waits
// when res stalls, the result register holds, then the input register
//   fills and evt.ready drops until res takes the waiting beat
// reset: mode idle, all counts zero, ticks_per_second back to 20,
//   both registers empty
module keypad_countdown_timer (
  input  logic                       clk,
  input  logic                       rst,
  kct_evt_if.sink                    evt,
  kct_res_if.source                  res,
  input  logic                       cfg_we,
  input  logic [kct_pkg::TpsW-1:0]   cfg_wdata
);
  import kct_pkg::*;

  // input register to step logic
  logic hold_valid;
  evt_t hold;

  // step logic to result register
  res_t step_res;
  logic space;
  logic fire;

  // an event is processed once the result register has room for it
  assign fire = hold_valid && space;

  kct_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .advance    (space),
    .hold_valid (hold_valid),
    .hold       (hold)
  );

  // timer state and its next-state logic, updated on each processed event
  kct_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (hold),
    .result    (step_res)
  );

  // result register driving the res channel
  kct_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .res   (res),
    .load  (fire),
    .data  (step_res),
    .space (space)
  );

endmodule
